>>> rtl/core/quaternion_arithmetic_unit_defines.svh
// ----------------------------------------------------------------------------
// quaternion arithmetic unit assertion macros
// ----------------------------------------------------------------------------
`ifndef QUATERNION_ARITHMETIC_UNIT_DEFINES_SVH
`define QUATERNION_ARITHMETIC_UNIT_DEFINES_SVH

// same-cycle implication
`define QAU_ASSERT_IMP(lbl, ck, rst_n, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("qau check failed");

// next-cycle implication
`define QAU_ASSERT_NXT(lbl, ck, rst_n, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("qau check failed");

`endif

>>> rtl/core/qau_pkg.sv
// ----------------------------------------------------------------------------
// qau_pkg
// Shared widths, command codes, trig table and step functions of the
// quaternion arithmetic unit.
// ----------------------------------------------------------------------------
package qau_pkg;

	localparam int CW          = 16;          // component width
	localparam int CMD_W       = 3;
	localparam int FRAC        = 12;          // fraction bits of a component
	localparam int TRIG_STEPS  = 16;
	localparam int STAGE_STEPS = TRIG_STEPS / 4;
	localparam int TI_W        = $clog2(TRIG_STEPS);
	localparam int PW          = 2 * CW;      // product width
	localparam int RAW_W       = PW + 3;      // matrix terms need the most room
	localparam int N_W         = PW + 1;      // sum of four squares
	localparam int SQ_W        = N_W + 1;
	localparam int ROOT_W      = CW + 1;
	localparam int SQ_TOP      = ROOT_W - 1;  // highest result bit of the root
	localparam int SQ_MAX_STEPS = 5;
	localparam int CX_W        = 34;          // cordic x and y, Q2.30 with margin
	localparam int Z_W         = 26;          // cordic angle, 2^-16 degree
	localparam int H_W         = CW + 2;      // half angle in 2^-7 degree
	localparam int Z_SHIFT     = 9;
	localparam int TRIG_FRAC   = 30;
	localparam int SP_W        = CW + CX_W;   // axis times sine
	localparam int SAT_W       = SP_W + 2;
	localparam int ROW_W       = 2;
	localparam int NROWS       = 3;

	localparam logic [ROW_W-1:0] LAST_ROW = ROW_W'(NROWS - 1);

	localparam logic signed [H_W-1:0] HALF_TURN    = H_W'(23040);
	localparam logic signed [H_W-1:0] FULL_TURN    = H_W'(46080);
	localparam logic signed [H_W-1:0] QUARTER_TURN = H_W'(11520);

	localparam logic signed [CX_W-1:0] CORDIC_GAIN = CX_W'(652032874);

	localparam logic signed [RAW_W-1:0] M_ONE = RAW_W'(1) <<< (2 * FRAC);

	localparam logic signed [SAT_W-1:0] RND_F  = SAT_W'(1) <<< (FRAC - 1);
	localparam logic signed [SAT_W-1:0] RND_C  = SAT_W'(1) <<< (TRIG_FRAC - FRAC - 1);
	localparam logic signed [SAT_W-1:0] RND_T  = SAT_W'(1) <<< (TRIG_FRAC - 1);
	localparam logic signed [SAT_W-1:0] SAT_HI = SAT_W'(2 ** (CW - 1) - 1);
	localparam logic signed [SAT_W-1:0] SAT_LO = -SAT_HI - SAT_W'(1);

	localparam logic signed [Z_W-1:0] ATAN [TRIG_STEPS] = '{
		Z_W'(2949120), Z_W'(1740967), Z_W'(919879), Z_W'(466945),
		Z_W'(234379),  Z_W'(117304),  Z_W'(58666),  Z_W'(29335),
		Z_W'(14668),   Z_W'(7334),    Z_W'(3667),   Z_W'(1833),
		Z_W'(917),     Z_W'(458),     Z_W'(229),    Z_W'(115)
	};

	typedef enum logic [CMD_W-1:0] {
		CMD_MUL    = 3'd0,
		CMD_ADD    = 3'd1,
		CMD_CONJ   = 3'd2,
		CMD_NORM   = 3'd3,
		CMD_AXIS   = 3'd4,
		CMD_MATRIX = 3'd5
	} cmd_t;

	typedef struct packed {
		logic signed [CX_W-1:0] x;
		logic signed [CX_W-1:0] y;
		logic signed [Z_W-1:0]  z;
	} cordic_t;

	typedef struct packed {
		logic [SQ_W-1:0] n;
		logic [SQ_W-1:0] root;
	} sqrt_t;

	typedef struct packed {
		logic [CW-1:0] v;
		logic          f;
	} sat_t;

	function automatic cordic_t cordic_step(cordic_t st, int i);
		cordic_t r;
		logic signed [CX_W-1:0] xs;
		logic signed [CX_W-1:0] ys;
		xs = $signed(st.x) >>> i;
		ys = $signed(st.y) >>> i;
		if (!st.z[Z_W-1]) begin
			r.x = st.x - ys;
			r.y = st.y + xs;
			r.z = st.z - ATAN[TI_W'(i)];
		end else begin
			r.x = st.x + ys;
			r.y = st.y - xs;
			r.z = st.z + ATAN[TI_W'(i)];
		end
		return r;
	endfunction

	function automatic cordic_t cordic_run(cordic_t st, int base);
		cordic_t t;
		t = st;
		for (int j = 0; j < STAGE_STEPS; j++)
			t = cordic_step(t, base + j);
		return t;
	endfunction

	function automatic sqrt_t sqrt_step(sqrt_t st, int k);
		sqrt_t r;
		logic [SQ_W-1:0] bitv;
		logic [SQ_W-1:0] trial;
		bitv  = SQ_W'(1) << (2 * k);
		trial = st.root + bitv;
		if (st.n >= trial) begin
			r.n    = st.n - trial;
			r.root = (st.root >> 1) + bitv;
		end else begin
			r.n    = st.n;
			r.root = st.root >> 1;
		end
		return r;
	endfunction

	function automatic sqrt_t sqrt_run(sqrt_t st, int hi, int cnt);
		sqrt_t t;
		t = st;
		for (int j = 0; j < SQ_MAX_STEPS; j++)
			if (j < cnt)
				t = sqrt_step(t, hi - j);
		return t;
	endfunction

	function automatic sat_t clip(input logic signed [SAT_W-1:0] v);
		sat_t r;
		if (v > SAT_HI) begin
			r.v = SAT_HI[CW-1:0];
			r.f = 1'b1;
		end else if (v < SAT_LO) begin
			r.v = SAT_LO[CW-1:0];
			r.f = 1'b1;
		end else begin
			r.v = v[CW-1:0];
			r.f = 1'b0;
		end
		return r;
	endfunction

endpackage

>>> rtl/core/qau_cordic.sv
// ----------------------------------------------------------------------------
// qau_cordic
// Four-stage rotation cordic giving cosine and sine of the folded half angle.
// ----------------------------------------------------------------------------
module qau_cordic (
	input  logic                                clk,
	input  logic                                en,
	input  logic signed [qau_pkg::Z_W-1:0]      z_in,
	output logic signed [qau_pkg::CX_W-1:0]     x_out,
	output logic signed [qau_pkg::CX_W-1:0]     y_out
);

	qau_pkg::cordic_t st0;
	qau_pkg::cordic_t c_s2, c_s3, c_s4, c_s5;

	always_comb begin
		st0.x = qau_pkg::CORDIC_GAIN;
		st0.y = '0;
		st0.z = z_in;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			c_s2 <= qau_pkg::cordic_run(st0, 0);
			c_s3 <= qau_pkg::cordic_run(c_s2, qau_pkg::STAGE_STEPS);
			c_s4 <= qau_pkg::cordic_run(c_s3, 2 * qau_pkg::STAGE_STEPS);
			c_s5 <= qau_pkg::cordic_run(c_s4, 3 * qau_pkg::STAGE_STEPS);
		end
	end

	assign x_out = c_s5.x;
	assign y_out = c_s5.y;

endmodule

>>> rtl/core/qau_isqrt.sv
// ----------------------------------------------------------------------------
// qau_isqrt
// Four-stage restoring integer square root of the sum of squares.
// ----------------------------------------------------------------------------
module qau_isqrt (
	input  logic                            clk,
	input  logic                            en,
	input  logic [qau_pkg::N_W-1:0]         n_in,
	output logic [qau_pkg::ROOT_W-1:0]      root
);

	qau_pkg::sqrt_t st0;
	qau_pkg::sqrt_t q_s3, q_s4, q_s5, q_s6;

	always_comb begin
		st0.n    = qau_pkg::SQ_W'(n_in);
		st0.root = '0;
	end

	// result bits 16..12, then four per stage
	always_ff @(posedge clk) begin
		if (en) begin
			q_s3 <= qau_pkg::sqrt_run(st0, qau_pkg::SQ_TOP, 5);
			q_s4 <= qau_pkg::sqrt_run(q_s3, qau_pkg::SQ_TOP - 5, 4);
			q_s5 <= qau_pkg::sqrt_run(q_s4, qau_pkg::SQ_TOP - 9, 4);
			q_s6 <= qau_pkg::sqrt_run(q_s5, qau_pkg::SQ_TOP - 13, 4);
		end
	end

	assign root = q_s6.root[qau_pkg::ROOT_W-1:0];

endmodule

>>> rtl/core/quaternion_arithmetic_unit.sv
// ----------------------------------------------------------------------------
// quaternion_arithmetic_unit
// Throughput: one item per cycle when out_stall is low; a matrix item holds the
// output while its three rows go out, one row each; the pipeline waits behind it.
// The product array, cordic and square root stages set the depth.
// Reset clears the stage valid bits and the row counter only.
// ----------------------------------------------------------------------------
module quaternion_arithmetic_unit (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [qau_pkg::CMD_W-1:0]     cmd,
	input  logic signed [qau_pkg::CW-1:0] a_s,
	input  logic signed [qau_pkg::CW-1:0] a_x,
	input  logic signed [qau_pkg::CW-1:0] a_y,
	input  logic signed [qau_pkg::CW-1:0] a_z,
	input  logic signed [qau_pkg::CW-1:0] b_s,
	input  logic signed [qau_pkg::CW-1:0] b_x,
	input  logic signed [qau_pkg::CW-1:0] b_y,
	input  logic signed [qau_pkg::CW-1:0] b_z,
	input  logic signed [qau_pkg::CW-1:0] angle_deg,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic signed [qau_pkg::CW-1:0] r0,
	output logic signed [qau_pkg::CW-1:0] r1,
	output logic signed [qau_pkg::CW-1:0] r2,
	output logic signed [qau_pkg::CW-1:0] r3,
	output logic [qau_pkg::ROW_W-1:0]     row_index,
	output logic                          last,
	output logic                          saturated
);

	localparam int CW    = qau_pkg::CW;
	localparam int RAW_W = qau_pkg::RAW_W;
	localparam int SAT_W = qau_pkg::SAT_W;

	logic en;
	logic last_c;

	// stage 1
	logic signed [CW-1:0] a_in [4];
	logic signed [CW-1:0] b_in [4];
	logic signed [CW-1:0] bop [4];
	logic signed [qau_pkg::H_W-1:0] h;
	logic neg_c;
	logic v_s1;
	qau_pkg::cmd_t cmd_s1;
	logic signed [CW-1:0] a_s1 [4];
	logic signed [CW-1:0] b_s1 [4];
	logic signed [qau_pkg::PW-1:0] p_s1 [4][4];
	logic signed [qau_pkg::Z_W-1:0] z_s1;
	logic neg_s1;

	// stage 2
	logic signed [RAW_W-1:0] pe [4][4];
	logic signed [RAW_W-1:0] raw_c [3][4];
	logic signed [RAW_W-1:0] n_sum;
	logic rnd_c;
	logic v_s2;
	qau_pkg::cmd_t cmd_s2;
	logic signed [RAW_W-1:0] raw_s2 [3][4];
	logic rnd_s2;
	logic [qau_pkg::N_W-1:0] n_s2;
	logic signed [CW-1:0] bv_s2 [3];
	logic neg_s2;

	// stage 3 to 6
	logic [CW-1:0] rows_c [3][4];
	logic sat_c [3];
	logic v_s3, v_s4, v_s5, v_s6;
	qau_pkg::cmd_t cmd_s3, cmd_s4, cmd_s5, cmd_s6;
	logic [CW-1:0] rows_s3 [3][4];
	logic [CW-1:0] rows_s4 [3][4];
	logic [CW-1:0] rows_s5 [3][4];
	logic [CW-1:0] rows_s6 [3][4];
	logic sat_s3 [3];
	logic sat_s4 [3];
	logic sat_s5 [3];
	logic sat_s6 [3];
	logic signed [CW-1:0] bv_s3 [3];
	logic signed [CW-1:0] bv_s4 [3];
	logic signed [CW-1:0] bv_s5 [3];
	logic neg_s3, neg_s4, neg_s5;
	logic signed [qau_pkg::CX_W-1:0] cx, cy, cs_c, sn_c;
	logic signed [qau_pkg::CX_W-1:0] cos_s6;
	logic signed [qau_pkg::SP_W-1:0] sp_s6 [3];
	logic [qau_pkg::ROOT_W-1:0] root;

	// output register
	logic [CW-1:0] nx_rows [3][4];
	logic nx_sat [3];
	qau_pkg::sat_t cl;
	logic out_v_q;
	logic [qau_pkg::ROW_W-1:0] row_q;
	logic mat_q;
	logic [CW-1:0] rows_q [3][4];
	logic sat_q [3];
	logic [CW-1:0] sel [4];
	logic sel_sat;

	assign last_c   = !mat_q || (row_q == qau_pkg::LAST_ROW);
	assign en       = !out_v_q || (!out_stall && last_c);
	assign in_stall = !en;

	// ---------------- stage 1: operands, products, half angle ----------------
	always_comb begin
		a_in[0] = a_s; a_in[1] = a_x; a_in[2] = a_y; a_in[3] = a_z;
		b_in[0] = b_s; b_in[1] = b_x; b_in[2] = b_y; b_in[3] = b_z;
		// norm and matrix square a against itself
		for (int j = 0; j < 4; j++)
			bop[j] = (cmd == qau_pkg::CMD_NORM || cmd == qau_pkg::CMD_MATRIX) ?
				a_in[j] : b_in[j];
	end

	always_comb begin
		h     = qau_pkg::H_W'(angle_deg);
		neg_c = 1'b0;
		if (h > qau_pkg::HALF_TURN)
			h = h - qau_pkg::FULL_TURN;
		if (h < -qau_pkg::HALF_TURN)
			h = h + qau_pkg::FULL_TURN;
		// fold into a quarter turn, cos and sin both change sign
		if (h > qau_pkg::QUARTER_TURN) begin
			h     = h - qau_pkg::HALF_TURN;
			neg_c = 1'b1;
		end
		if (h < -qau_pkg::QUARTER_TURN) begin
			h     = h + qau_pkg::HALF_TURN;
			neg_c = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			cmd_s1 <= qau_pkg::cmd_t'(cmd);
			for (int i = 0; i < 4; i++) begin
				a_s1[i] <= a_in[i];
				b_s1[i] <= b_in[i];
				for (int j = 0; j < 4; j++)
					p_s1[i][j] <= a_in[i] * bop[j];
			end
			z_s1   <= qau_pkg::Z_W'(h) <<< qau_pkg::Z_SHIFT;
			neg_s1 <= neg_c;
		end
	end

	// ---------------- stage 2: sums of products ----------------
	always_comb begin
		for (int i = 0; i < 4; i++)
			for (int j = 0; j < 4; j++)
				pe[i][j] = RAW_W'(p_s1[i][j]);
		raw_c = '{default: '0};
		rnd_c = 1'b0;
		unique case (cmd_s1)
			qau_pkg::CMD_MUL: begin
				rnd_c = 1'b1;
				raw_c[0][0] = pe[0][0] - pe[1][1] - pe[2][2] - pe[3][3];
				raw_c[0][1] = pe[0][1] + pe[1][0] + pe[2][3] - pe[3][2];
				raw_c[0][2] = pe[0][2] - pe[1][3] + pe[2][0] + pe[3][1];
				raw_c[0][3] = pe[0][3] + pe[1][2] - pe[2][1] + pe[3][0];
			end
			qau_pkg::CMD_ADD: begin
				for (int j = 0; j < 4; j++)
					raw_c[0][j] = RAW_W'(a_s1[j]) + RAW_W'(b_s1[j]);
			end
			qau_pkg::CMD_CONJ: begin
				raw_c[0][0] = RAW_W'(a_s1[0]);
				for (int j = 1; j < 4; j++)
					raw_c[0][j] = -RAW_W'(a_s1[j]);
			end
			qau_pkg::CMD_MATRIX: begin
				rnd_c = 1'b1;
				raw_c[0][0] = qau_pkg::M_ONE - ((pe[2][2] + pe[3][3]) <<< 1);
				raw_c[0][1] = (pe[1][2] - pe[3][0]) <<< 1;
				raw_c[0][2] = (pe[1][3] + pe[2][0]) <<< 1;
				raw_c[1][0] = (pe[1][2] + pe[3][0]) <<< 1;
				raw_c[1][1] = qau_pkg::M_ONE - ((pe[1][1] + pe[3][3]) <<< 1);
				raw_c[1][2] = (pe[2][3] - pe[1][0]) <<< 1;
				raw_c[2][0] = (pe[1][3] - pe[2][0]) <<< 1;
				raw_c[2][1] = (pe[2][3] + pe[1][0]) <<< 1;
				raw_c[2][2] = qau_pkg::M_ONE - ((pe[1][1] + pe[2][2]) <<< 1);
			end
			default: begin
			end
		endcase
		n_sum = pe[0][0] + pe[1][1] + pe[2][2] + pe[3][3];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			cmd_s2 <= cmd_s1;
			raw_s2 <= raw_c;
			rnd_s2 <= rnd_c;
			n_s2   <= n_sum[qau_pkg::N_W-1:0];
			for (int j = 0; j < 3; j++)
				bv_s2[j] <= b_s1[j + 1];
			neg_s2 <= neg_s1;
		end
	end

	// ---------------- stage 3: round and clip ----------------
	always_comb begin
		logic signed [SAT_W-1:0] w;
		qau_pkg::sat_t c;
		for (int k = 0; k < 3; k++) begin
			sat_c[k] = 1'b0;
			for (int j = 0; j < 4; j++) begin
				w = SAT_W'(raw_s2[k][j]);
				if (rnd_s2)
					w = (w + qau_pkg::RND_F) >>> qau_pkg::FRAC;
				c = qau_pkg::clip(w);
				rows_c[k][j] = c.v;
				sat_c[k] = sat_c[k] | c.f;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			cmd_s3  <= cmd_s2;  cmd_s4  <= cmd_s3;  cmd_s5  <= cmd_s4;  cmd_s6  <= cmd_s5;
			rows_s3 <= rows_c;  rows_s4 <= rows_s3; rows_s5 <= rows_s4; rows_s6 <= rows_s5;
			sat_s3  <= sat_c;   sat_s4  <= sat_s3;  sat_s5  <= sat_s4;  sat_s6  <= sat_s5;
			bv_s3   <= bv_s2;   bv_s4   <= bv_s3;   bv_s5   <= bv_s4;
			neg_s3  <= neg_s2;  neg_s4  <= neg_s3;  neg_s5  <= neg_s4;
		end
	end

	qau_cordic u_cordic (
		.clk   (clk),
		.en    (en),
		.z_in  (z_s1),
		.x_out (cx),
		.y_out (cy)
	);

	qau_isqrt u_isqrt (
		.clk  (clk),
		.en   (en),
		.n_in (n_s2),
		.root (root)
	);

	// ---------------- stage 6: axis times sine ----------------
	assign cs_c = neg_s5 ? -cx : cx;
	assign sn_c = neg_s5 ? -cy : cy;

	always_ff @(posedge clk) begin
		if (en) begin
			cos_s6 <= cs_c;
			for (int j = 0; j < 3; j++)
				sp_s6[j] <= bv_s5[j] * sn_c;
		end
	end

	// ---------------- output register ----------------
	always_comb begin
		nx_rows = rows_s6;
		nx_sat  = sat_s6;
		cl      = '0;
		unique case (cmd_s6)
			qau_pkg::CMD_NORM: begin
				cl = qau_pkg::clip($signed(SAT_W'(root)));
				nx_rows[0][0] = cl.v;
				for (int j = 1; j < 4; j++)
					nx_rows[0][j] = '0;
				nx_sat[0] = cl.f;
			end
			qau_pkg::CMD_AXIS: begin
				cl = qau_pkg::clip((SAT_W'(cos_s6) + qau_pkg::RND_C)
					>>> (qau_pkg::TRIG_FRAC - qau_pkg::FRAC));
				nx_rows[0][0] = cl.v;
				nx_sat[0]     = cl.f;
				for (int j = 0; j < 3; j++) begin
					cl = qau_pkg::clip((SAT_W'(sp_s6[j]) + qau_pkg::RND_T)
						>>> qau_pkg::TRIG_FRAC);
					nx_rows[0][j + 1] = cl.v;
					nx_sat[0] = nx_sat[0] | cl.f;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1    <= 1'b0;
			v_s2    <= 1'b0;
			v_s3    <= 1'b0;
			v_s4    <= 1'b0;
			v_s5    <= 1'b0;
			v_s6    <= 1'b0;
			out_v_q <= 1'b0;
			row_q   <= '0;
		end else if (en) begin
			v_s1    <= in_valid;
			v_s2    <= v_s1;
			v_s3    <= v_s2;
			v_s4    <= v_s3;
			v_s5    <= v_s4;
			v_s6    <= v_s5;
			out_v_q <= v_s6;
			row_q   <= '0;
		end else if (out_v_q && !out_stall) begin
			row_q <= row_q + qau_pkg::ROW_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rows_q <= nx_rows;
			sat_q  <= nx_sat;
			mat_q  <= (cmd_s6 == qau_pkg::CMD_MATRIX);
		end
	end

	always_comb begin
		case (row_q)
			2'd1: begin
				sel     = rows_q[1];
				sel_sat = sat_q[1];
			end
			2'd2: begin
				sel     = rows_q[2];
				sel_sat = sat_q[2];
			end
			default: begin
				sel     = rows_q[0];
				sel_sat = sat_q[0];
			end
		endcase
	end

	assign out_valid = out_v_q;
	assign r0        = sel[0];
	assign r1        = sel[1];
	assign r2        = sel[2];
	assign r3        = sel[3];
	assign row_index = row_q;
	assign last      = last_c;
	assign saturated = sel_sat;

endmodule

>>> rtl/core/qau_checker.sv
// ----------------------------------------------------------------------------
// qau_checker
// Port-level checks of the result channel, bound to the top level.
// ----------------------------------------------------------------------------
`include "quaternion_arithmetic_unit_defines.svh"

module qau_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          out_valid,
	input logic                          out_stall,
	input logic signed [qau_pkg::CW-1:0] r0,
	input logic signed [qau_pkg::CW-1:0] r1,
	input logic signed [qau_pkg::CW-1:0] r3,
	input logic [qau_pkg::ROW_W-1:0]     row_index,
	input logic                          last
);

	// only three matrix rows exist
	`QAU_ASSERT_IMP(a_row_range, clk, arst_n, out_valid, row_index != 2'd3)

	`QAU_ASSERT_IMP(a_row2_last, clk, arst_n, out_valid && row_index == qau_pkg::LAST_ROW, last)

	// matrix rows carry no k column
	`QAU_ASSERT_IMP(a_row_k0, clk, arst_n, out_valid && row_index != 2'd0, r3 == '0)

	// a taken row that is not last is followed by the next row of the same item
	`QAU_ASSERT_NXT(a_row_step, clk, arst_n, out_valid && !out_stall && !last, out_valid && row_index == 2'($past(row_index) + 2'd1))

	`QAU_ASSERT_NXT(a_hold, clk, arst_n, out_valid && out_stall, out_valid && $stable(r0) && $stable(r1) && $stable(row_index) && $stable(last))

endmodule

bind quaternion_arithmetic_unit qau_checker u_qau_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.r0        (r0),
	.r1        (r1),
	.r3        (r3),
	.row_index (row_index),
	.last      (last)
);
